[design/tgbd_pkg.sv]
package tgbd_pkg;

	// Default table depth
	localparam int unsigned DEF_MAX_TILESETS = 8;

	// Field widths
	localparam int unsigned GID_W     = 29;
	localparam int unsigned COL_W     = 12;
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned TSZ_W     = 9;
	localparam int unsigned SZ_W      = 10;
	localparam int unsigned CELL_W    = 10;
	localparam int unsigned DST_W     = 19;
	localparam int unsigned SRC_W     = 25;
	localparam int unsigned QUOT_W    = 16;
	localparam int unsigned IDX_MAX_W = 5;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned ROT_W     = 2;
	localparam int unsigned FLAG_W    = 3;

	// Flip flag positions inside the three flag bits
	localparam int unsigned FLAG_H = 2;
	localparam int unsigned FLAG_V = 1;
	localparam int unsigned FLAG_D = 0;

	localparam logic [SRC_W-1:0] SRC_SAT = '1;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		CFG_TILE_W    = 2'd0,
		CFG_TILE_H    = 2'd1,
		CFG_SET_COUNT = 2'd2
	} cfg_addr_t;

	typedef enum logic [ROT_W-1:0] {
		ROT_NONE = 2'd0,
		ROT_90   = 2'd1,
		ROT_270  = 2'd2
	} rot_t;

	// Per-tile data carried alongside the divider
	typedef struct packed {
		logic                 drawn;
		logic [IDX_MAX_W-1:0] idx;
		logic [PIX_W-1:0]     margin;
		logic [SZ_W-1:0]      pitch_x;
		logic [SZ_W-1:0]      pitch_y;
		logic [SZ_W-1:0]      sw;
		logic [SZ_W-1:0]      sh;
		logic [DST_W-1:0]     dst_x;
		logic [DST_W-1:0]     dst_y;
		rot_t                 rot;
	} side_t;

endpackage

[design/tgbd_lookup.sv]
module tgbd_lookup import tgbd_pkg::*; #(
	parameter int unsigned MAX_TILESETS = DEF_MAX_TILESETS,
	parameter int unsigned IDX_W = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_acc,
	input  logic              mode,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [GID_W-1:0]  first_gid,
	input  logic [COL_W-1:0]  sheet_columns,
	input  logic [PIX_W-1:0]  sheet_margin,
	input  logic [PIX_W-1:0]  sheet_spacing,
	input  logic [TSZ_W-1:0]  sheet_tile_width,
	input  logic [TSZ_W-1:0]  sheet_tile_height,
	input  logic              has_texture,
	input  logic [31:0]       raw_word,
	input  logic [CELL_W-1:0] cell_x,
	input  logic [CELL_W-1:0] cell_y,
	input  logic [TSZ_W-1:0]  map_w,
	input  logic [TSZ_W-1:0]  map_h,
	input  logic [CNT_W-1:0]  set_count,
	output logic              vld_s2,
	output side_t             side_s2,
	output logic [QUOT_W-1:0] local_s2,
	output logic [COL_W-1:0]  cols_s2
);

	localparam int unsigned UW = 6;
	localparam int unsigned IDX1_W = IDX_W + 1;

	logic [GID_W-1:0] tbl_first_q [MAX_TILESETS];
	logic [COL_W-1:0] tbl_cols_q  [MAX_TILESETS];
	logic [PIX_W-1:0] tbl_marg_q  [MAX_TILESETS];
	logic [PIX_W-1:0] tbl_spac_q  [MAX_TILESETS];
	logic [TSZ_W-1:0] tbl_tw_q    [MAX_TILESETS];
	logic [TSZ_W-1:0] tbl_th_q    [MAX_TILESETS];
	logic             tbl_tex_q   [MAX_TILESETS];

	logic [GID_W-1:0] gid;
	logic [UW-1:0]    used;
	logic             hit;
	logic [IDX_W-1:0] sel;

	logic              vld_s1;
	logic              hit_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [GID_W-1:0]  gid_s1;
	logic [GID_W-1:0]  first_s1;
	logic [COL_W-1:0]  cols_s1;
	logic [PIX_W-1:0]  marg_s1;
	logic [PIX_W-1:0]  spac_s1;
	logic [TSZ_W-1:0]  tw_s1;
	logic [TSZ_W-1:0]  th_s1;
	logic              tex_s1;
	logic [FLAG_W-1:0] flags_s1;
	logic [CELL_W-1:0] cx_s1;
	logic [CELL_W-1:0] cy_s1;

	logic [GID_W-1:0]  rel_id;
	logic              ok;
	logic [SZ_W-1:0]   tw_ext;
	logic [SZ_W-1:0]   th_ext;
	logic [SZ_W-1:0]   sw;
	logic [SZ_W-1:0]   sh;
	logic [TSZ_W-1:0]  shift_x;
	logic [TSZ_W-1:0]  shift_y;
	rot_t              rot;
	logic [DST_W:0]    dst_x_full;
	logic [DST_W:0]    dst_y_full;
	side_t             side_d;

	// Write one table entry per load word
	always_ff @(posedge clk) begin
		if (in_acc && !mode && ({1'b0, entry_index} < IDX1_W'(MAX_TILESETS))) begin
			tbl_first_q[entry_index] <= first_gid;
			tbl_cols_q[entry_index]  <= sheet_columns;
			tbl_marg_q[entry_index]  <= sheet_margin;
			tbl_spac_q[entry_index]  <= sheet_spacing;
			tbl_tw_q[entry_index]    <= sheet_tile_width;
			tbl_th_q[entry_index]    <= sheet_tile_height;
			tbl_tex_q[entry_index]   <= has_texture;
		end
	end

	// Find the highest entry in use whose first id does not exceed the id
	always_comb begin
		gid  = raw_word[GID_W-1:0];
		used = ({2'b00, set_count} > UW'(MAX_TILESETS)) ? UW'(MAX_TILESETS)
			: {2'b00, set_count};
		hit  = 1'b0;
		sel  = '0;
		for (int i = 0; i < MAX_TILESETS; i++) begin
			if ((UW'(i) < used) && (tbl_first_q[i] <= gid)) begin
				hit = 1'b1;
				sel = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_acc && mode;
		end
	end

	// Latch the chosen entry
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1   <= hit && (gid != '0);
			idx_s1   <= sel;
			gid_s1   <= gid;
			first_s1 <= tbl_first_q[sel];
			cols_s1  <= tbl_cols_q[sel];
			marg_s1  <= tbl_marg_q[sel];
			spac_s1  <= tbl_spac_q[sel];
			tw_s1    <= tbl_tw_q[sel];
			th_s1    <= tbl_th_q[sel];
			tex_s1   <= tbl_tex_q[sel];
			flags_s1 <= raw_word[31:29];
			cx_s1    <= cell_x;
			cy_s1    <= cell_y;
		end
	end

	// Local id, skip checks, flips and destination corner
	always_comb begin
		rel_id = gid_s1 - first_s1;
		ok = hit_s1 && tex_s1 && (cols_s1 != '0) && (rel_id[GID_W-1:QUOT_W] == '0);
		tw_ext  = {1'b0, tw_s1};
		th_ext  = {1'b0, th_s1};
		sw      = tw_ext;
		sh      = th_ext;
		shift_x = '0;
		shift_y = '0;
		rot     = ROT_NONE;
		if (flags_s1[FLAG_D]) begin
			if (flags_s1[FLAG_H]) begin
				rot     = ROT_90;
				shift_x = map_w;
				if (flags_s1[FLAG_V]) sw = -tw_ext;
			end else begin
				rot     = ROT_270;
				shift_y = map_h;
				if (!flags_s1[FLAG_V]) sw = -tw_ext;
			end
		end else begin
			if (flags_s1[FLAG_H]) sw = -tw_ext;
			if (flags_s1[FLAG_V]) sh = -th_ext;
		end
		dst_x_full = (DST_W+1)'(cx_s1) * (DST_W+1)'(map_w) + (DST_W+1)'(shift_x);
		dst_y_full = (DST_W+1)'(cy_s1) * (DST_W+1)'(map_h) + (DST_W+1)'(shift_y);

		side_d.drawn   = ok;
		side_d.idx     = IDX_MAX_W'(idx_s1);
		side_d.margin  = marg_s1;
		side_d.pitch_x = tw_ext + {2'b00, spac_s1};
		side_d.pitch_y = th_ext + {2'b00, spac_s1};
		side_d.sw      = sw;
		side_d.sh      = sh;
		side_d.dst_x   = dst_x_full[DST_W-1:0];
		side_d.dst_y   = dst_y_full[DST_W-1:0];
		side_d.rot     = rot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2  <= side_d;
			local_s2 <= rel_id[QUOT_W-1:0];
			cols_s2  <= cols_s1;
		end
	end

endmodule

[design/tgbd_div.sv]
module tgbd_div import tgbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  side_t             in_side,
	input  logic [QUOT_W-1:0] dividend,
	input  logic [COL_W-1:0]  divisor,
	output logic              out_vld,
	output side_t             out_side,
	output logic [QUOT_W-1:0] quo,
	output logic [COL_W-1:0]  rem
);

	// Index 0 is the input, index k holds the word after k quotient bits
	logic              vld_s  [QUOT_W+1];
	side_t             side_s [QUOT_W+1];
	logic [QUOT_W-1:0] num_s  [QUOT_W+1];
	logic [QUOT_W-1:0] quo_s  [QUOT_W+1];
	logic [COL_W-1:0]  rem_s  [QUOT_W+1];
	logic [COL_W-1:0]  dvs_s  [QUOT_W+1];

	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;
	assign num_s[0]  = dividend;
	assign quo_s[0]  = '0;
	assign rem_s[0]  = '0;
	assign dvs_s[0]  = divisor;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_step
		logic [COL_W:0] trial;
		logic [COL_W:0] diff;
		logic           ge;

		// One restoring step: shift in the next dividend bit, subtract if it fits
		always_comb begin
			trial = {rem_s[k], num_s[k][QUOT_W-1]};
			diff  = trial - {1'b0, dvs_s[k]};
			ge    = trial >= {1'b0, dvs_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				num_s[k+1]  <= {num_s[k][QUOT_W-2:0], 1'b0};
				quo_s[k+1]  <= {quo_s[k][QUOT_W-2:0], ge};
				rem_s[k+1]  <= ge ? diff[COL_W-1:0] : trial[COL_W-1:0];
				dvs_s[k+1]  <= dvs_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QUOT_W];
	assign out_side = side_s[QUOT_W];
	assign quo      = quo_s[QUOT_W];
	assign rem      = rem_s[QUOT_W];

endmodule

[design/tile_gid_to_blit_decoder_core.sv]
// Stages from input accept to result valid: lookup, prepare,
// 16 divider steps, multiply, output register.
// Throughput: one word per cycle unless stalled; a load word produces no result.
// The 16-stage quotient pipeline sets the depth; a stall freezes all stages.
// Reset clears valid bits and sets map tile size to 16x16, tileset count 0.
// The tileset table is not reset and holds garbage until loaded.
module tile_gid_to_blit_decoder_core import tgbd_pkg::*; #(
	parameter int unsigned MAX_TILESETS = DEF_MAX_TILESETS,
	parameter int unsigned IDX_W = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_addr,
	input  logic [TSZ_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    mode,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic [GID_W-1:0]        first_gid,
	input  logic [COL_W-1:0]        sheet_columns,
	input  logic [PIX_W-1:0]        sheet_margin,
	input  logic [PIX_W-1:0]        sheet_spacing,
	input  logic [TSZ_W-1:0]        sheet_tile_width,
	input  logic [TSZ_W-1:0]        sheet_tile_height,
	input  logic                    has_texture,
	input  logic [31:0]             raw_word,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    drawn,
	output logic [IDX_W-1:0]        set_index,
	output logic [SRC_W-1:0]        src_x,
	output logic [SRC_W-1:0]        src_y,
	output logic signed [SZ_W-1:0]  src_w,
	output logic signed [SZ_W-1:0]  src_h,
	output logic [DST_W-1:0]        dst_x,
	output logic [DST_W-1:0]        dst_y,
	output logic [ROT_W-1:0]        rotation
);

	logic [TSZ_W-1:0] map_w_q;
	logic [TSZ_W-1:0] map_h_q;
	logic [CNT_W-1:0] set_count_q;

	logic              en;
	logic              in_acc;
	logic              vld_s2;
	side_t             side_s2;
	logic [QUOT_W-1:0] local_s2;
	logic [COL_W-1:0]  cols_s2;
	logic              div_vld;
	side_t             div_side;
	logic [QUOT_W-1:0] div_quo;
	logic [COL_W-1:0]  div_rem;

	logic              vld_s3;
	side_t             side_s3;
	logic [COL_W+SZ_W-1:0]  prod_x_s3;
	logic [QUOT_W+SZ_W-1:0] prod_y_s3;
	logic [QUOT_W+SZ_W:0]   sum_x;
	logic [QUOT_W+SZ_W:0]   sum_y;

	logic              out_valid_q;
	logic              drawn_q;
	logic [IDX_W-1:0]  set_index_q;
	logic [SRC_W-1:0]  src_x_q;
	logic [SRC_W-1:0]  src_y_q;
	logic [SZ_W-1:0]   src_w_q;
	logic [SZ_W-1:0]   src_h_q;
	logic [DST_W-1:0]  dst_x_q;
	logic [DST_W-1:0]  dst_y_q;
	logic [ROT_W-1:0]  rotation_q;

	// Advance the whole pipe unless a finished word is held at the output
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign in_acc    = in_valid && en;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q     <= TSZ_W'(16);
			map_h_q     <= TSZ_W'(16);
			set_count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_addr_t'(cfg_addr))
				CFG_TILE_W:    map_w_q     <= cfg_data;
				CFG_TILE_H:    map_h_q     <= cfg_data;
				CFG_SET_COUNT: set_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	tgbd_lookup #(
		.MAX_TILESETS (MAX_TILESETS),
		.IDX_W        (IDX_W)
	) u_lookup (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.in_acc            (in_acc),
		.mode              (mode),
		.entry_index       (entry_index),
		.first_gid         (first_gid),
		.sheet_columns     (sheet_columns),
		.sheet_margin      (sheet_margin),
		.sheet_spacing     (sheet_spacing),
		.sheet_tile_width  (sheet_tile_width),
		.sheet_tile_height (sheet_tile_height),
		.has_texture       (has_texture),
		.raw_word          (raw_word),
		.cell_x            (cell_x),
		.cell_y            (cell_y),
		.map_w             (map_w_q),
		.map_h             (map_h_q),
		.set_count         (set_count_q),
		.vld_s2            (vld_s2),
		.side_s2           (side_s2),
		.local_s2          (local_s2),
		.cols_s2           (cols_s2)
	);

	tgbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_side  (side_s2),
		.dividend (local_s2),
		.divisor  (cols_s2),
		.out_vld  (div_vld),
		.out_side (div_side),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Scale column and row by the tile pitch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3   <= div_side;
			prod_x_s3 <= div_rem * div_side.pitch_x;
			prod_y_s3 <= div_quo * div_side.pitch_y;
		end
	end

	// Add the margin and saturate the source corner
	always_comb begin
		sum_x = (QUOT_W+SZ_W+1)'(prod_x_s3) + (QUOT_W+SZ_W+1)'(side_s3.margin);
		sum_y = (QUOT_W+SZ_W+1)'(prod_y_s3) + (QUOT_W+SZ_W+1)'(side_s3.margin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s3;
		end
	end

	// Skipped tiles drop to an all-zero word
	always_ff @(posedge clk) begin
		if (en) begin
			drawn_q     <= side_s3.drawn;
			set_index_q <= side_s3.drawn ? side_s3.idx[IDX_W-1:0] : '0;
			src_x_q     <= !side_s3.drawn ? '0
				: ((sum_x[QUOT_W+SZ_W:SRC_W] != '0) ? SRC_SAT : sum_x[SRC_W-1:0]);
			src_y_q     <= !side_s3.drawn ? '0
				: ((sum_y[QUOT_W+SZ_W:SRC_W] != '0) ? SRC_SAT : sum_y[SRC_W-1:0]);
			src_w_q     <= side_s3.drawn ? side_s3.sw : '0;
			src_h_q     <= side_s3.drawn ? side_s3.sh : '0;
			dst_x_q     <= side_s3.drawn ? side_s3.dst_x : '0;
			dst_y_q     <= side_s3.drawn ? side_s3.dst_y : '0;
			rotation_q  <= side_s3.drawn ? side_s3.rot : ROT_NONE;
		end
	end

	assign out_valid = out_valid_q;
	assign drawn     = drawn_q;
	assign set_index = set_index_q;
	assign src_x     = src_x_q;
	assign src_y     = src_y_q;
	assign src_w     = src_w_q;
	assign src_h     = src_h_q;
	assign dst_x     = dst_x_q;
	assign dst_y     = dst_y_q;
	assign rotation  = rotation_q;

	// A skipped tile carries no geometry
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !drawn) |-> (src_x == '0 && src_y == '0 && src_w == '0
			&& dst_x == '0 && dst_y == '0))
		else $error("skipped tile with nonzero geometry");

	// Rotation only on drawn tiles
	a_rot_drawn: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rotation != ROT_NONE) |-> drawn)
		else $error("rotation on skipped tile");

	// Never the unused rotation code
	a_rot_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rotation == ROT_NONE || rotation == ROT_90 || rotation == ROT_270))
		else $error("bad rotation code");

	// A held result word keeps the pipe frozen
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(vld_s3) && out_valid)
		else $error("pipe moved under stall");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import tgbd_pkg::*;

	localparam int unsigned N_SETS = 8;
	localparam int unsigned WATCH_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 30;

	typedef struct {
		logic             mode;
		logic [2:0]       entry_index;
		logic [GID_W-1:0] first_gid;
		logic [COL_W-1:0] sheet_columns;
		logic [PIX_W-1:0] sheet_margin;
		logic [PIX_W-1:0] sheet_spacing;
		logic [TSZ_W-1:0] sheet_tile_width;
		logic [TSZ_W-1:0] sheet_tile_height;
		logic             has_texture;
		logic [31:0]      raw_word;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
	} tile_word_t;

	typedef struct {
		logic              drawn;
		logic [2:0]        set_index;
		logic [SRC_W-1:0]  src_x;
		logic [SRC_W-1:0]  src_y;
		logic [SZ_W-1:0]   src_w;
		logic [SZ_W-1:0]   src_h;
		logic [DST_W-1:0]  dst_x;
		logic [DST_W-1:0]  dst_y;
		logic [ROT_W-1:0]  rotation;
	} blit_t;

	typedef struct {
		logic [GID_W-1:0] first_gid;
		logic [COL_W-1:0] columns;
		logic [PIX_W-1:0] margin;
		logic [PIX_W-1:0] spacing;
		logic [TSZ_W-1:0] tw;
		logic [TSZ_W-1:0] th;
		logic             tex;
	} sheet_t;

	class blit_scoreboard;
		sheet_t     sheets[N_SETS];
		logic [8:0] tile_w;
		logic [8:0] tile_h;
		logic [3:0] set_count;
		blit_t      pending_blits[$];
		int         mismatches;
		int         checked;
		int         drawn_seen;
		int         loads;

		function new();
			tile_w = 9'd16;
			tile_h = 9'd16;
			set_count = '0;
		endfunction

		function void write_reg(cfg_addr_t a, logic [8:0] d);
			case (a)
				CFG_TILE_W: tile_w = d;
				CFG_TILE_H: tile_h = d;
				CFG_SET_COUNT: set_count = d[3:0];
				default: ;
			endcase
		endfunction

		// Update the table on a load word, predict a blit on a tile word
		function void note_word(tile_word_t w);
			blit_t b;
			logic [GID_W-1:0] gid;
			int used, found;
			longint unsigned rel_id, col, row, sx, sy;
			logic signed [SZ_W-1:0] sw, sh;
			longint unsigned shx, shy, dx, dy;
			rot_t rot;
			sheet_t e;
			if (!w.mode) begin
				sheets[w.entry_index] = '{w.first_gid, w.sheet_columns, w.sheet_margin,
					w.sheet_spacing, w.sheet_tile_width, w.sheet_tile_height, w.has_texture};
				loads++;
				return;
			end
			b = '{default: '0};
			gid = w.raw_word[GID_W-1:0];
			found = -1;
			used = (set_count > N_SETS) ? N_SETS : set_count;
			if (gid != 0) begin
				for (int i = used; i > 0; i--) begin
					if (sheets[i-1].first_gid <= gid) begin
						found = i - 1;
						break;
					end
				end
			end
			if (found >= 0) begin
				e = sheets[found];
				rel_id = 64'(gid) - 64'(e.first_gid);
				if (e.tex && e.columns != 0 && rel_id <= 65535) begin
					col = rel_id % 64'(e.columns);
					row = rel_id / 64'(e.columns);
					sw = {1'b0, e.tw};
					sh = {1'b0, e.th};
					shx = 0;
					shy = 0;
					rot = ROT_NONE;
					if (w.raw_word[29]) begin
						if (w.raw_word[31]) begin
							rot = ROT_90;
							shx = 64'(tile_w);
							if (w.raw_word[30]) sw = -sw;
						end else begin
							rot = ROT_270;
							shy = 64'(tile_h);
							if (!w.raw_word[30]) sw = -sw;
						end
					end else begin
						if (w.raw_word[31]) sw = -sw;
						if (w.raw_word[30]) sh = -sh;
					end
					sx = 64'(e.margin) + col * (64'(e.tw) + 64'(e.spacing));
					sy = 64'(e.margin) + row * (64'(e.th) + 64'(e.spacing));
					dx = 64'(w.cell_x) * 64'(tile_w) + shx;
					dy = 64'(w.cell_y) * 64'(tile_h) + shy;
					b.drawn = 1'b1;
					b.set_index = 3'(found);
					b.src_x = (sx > SRC_SAT) ? SRC_SAT : sx[SRC_W-1:0];
					b.src_y = (sy > SRC_SAT) ? SRC_SAT : sy[SRC_W-1:0];
					b.src_w = sw;
					b.src_h = sh;
					b.dst_x = dx[DST_W-1:0];
					b.dst_y = dy[DST_W-1:0];
					b.rotation = rot;
				end
			end
			pending_blits.push_back(b);
		endfunction

		function void report(string what, longint unsigned exp_v, longint unsigned act_v);
			if (mismatches < 10)
				$display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, act_v, $realtime);
			mismatches++;
		endfunction

		// Compare a result word with the oldest prediction
		function void check_blit(blit_t a);
			blit_t x;
			if (pending_blits.size() == 0) begin
				report("unexpected result", 0, 1);
				return;
			end
			x = pending_blits.pop_front();
			checked++;
			if (a.drawn) drawn_seen++;
			if (a.drawn !== x.drawn) report("drawn", x.drawn, a.drawn);
			if (a.set_index !== x.set_index) report("set_index", x.set_index, a.set_index);
			if (a.src_x !== x.src_x) report("src_x", x.src_x, a.src_x);
			if (a.src_y !== x.src_y) report("src_y", x.src_y, a.src_y);
			if (a.src_w !== x.src_w) report("src_w", x.src_w, a.src_w);
			if (a.src_h !== x.src_h) report("src_h", x.src_h, a.src_h);
			if (a.dst_x !== x.dst_x) report("dst_x", x.dst_x, a.dst_x);
			if (a.dst_y !== x.dst_y) report("dst_y", x.dst_y, a.dst_y);
			if (a.rotation !== x.rotation) report("rotation", x.rotation, a.rotation);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_addr = '0;
	logic [TSZ_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [2:0] entry_index = '0;
	logic [GID_W-1:0] first_gid = '0;
	logic [COL_W-1:0] sheet_columns = '0;
	logic [PIX_W-1:0] sheet_margin = '0;
	logic [PIX_W-1:0] sheet_spacing = '0;
	logic [TSZ_W-1:0] sheet_tile_width = '0;
	logic [TSZ_W-1:0] sheet_tile_height = '0;
	logic has_texture = 1'b0;
	logic [31:0] raw_word = '0;
	logic [CELL_W-1:0] cell_x = '0;
	logic [CELL_W-1:0] cell_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic drawn;
	logic [2:0] set_index;
	logic [SRC_W-1:0] src_x, src_y;
	logic signed [SZ_W-1:0] src_w, src_h;
	logic [DST_W-1:0] dst_x, dst_y;
	logic [ROT_W-1:0] rotation;

	blit_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_go = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;

	tile_gid_to_blit_decoder_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Note accepted words on both sides
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_word('{mode, entry_index, first_gid, sheet_columns, sheet_margin,
				sheet_spacing, sheet_tile_width, sheet_tile_height, has_texture,
				raw_word, cell_x, cell_y});
		if (out_valid && !out_stall)
			sb.check_blit('{drawn, set_index, src_x, src_y, src_w, src_h, dst_x, dst_y,
				rotation});
	end

	// Stall the result side, with one long hold
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 0;
				repeat (400) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("[tile_gid_to_blit_decoder_core] ERROR");
			$finish;
		end
	end

	task automatic write_reg(cfg_addr_t a, logic [8:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= a;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(a, d);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Present one word, with random gaps ahead of it
	task automatic send_word(tile_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= w.mode;
		entry_index <= w.entry_index;
		first_gid <= w.first_gid;
		sheet_columns <= w.sheet_columns;
		sheet_margin <= w.sheet_margin;
		sheet_spacing <= w.sheet_spacing;
		sheet_tile_width <= w.sheet_tile_width;
		sheet_tile_height <= w.sheet_tile_height;
		has_texture <= w.has_texture;
		raw_word <= w.raw_word;
		cell_x <= w.cell_x;
		cell_y <= w.cell_y;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid right after the last accepted word, then wait for the results
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_blits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic tile_word_t load_word(int idx, int fg, int cols, int mar, int spa,
		int tw, int th, bit tex);
		tile_word_t w;
		w = '{default: '0};
		w.entry_index = 3'(idx);
		w.first_gid = GID_W'(fg);
		w.sheet_columns = COL_W'(cols);
		w.sheet_margin = PIX_W'(mar);
		w.sheet_spacing = PIX_W'(spa);
		w.sheet_tile_width = TSZ_W'(tw);
		w.sheet_tile_height = TSZ_W'(th);
		w.has_texture = tex;
		w.raw_word = $urandom();
		return w;
	endfunction

	function automatic tile_word_t tile_word(logic [31:0] raw, int cx, int cy);
		tile_word_t w;
		w = '{default: '0};
		w.mode = 1'b1;
		w.raw_word = raw;
		w.cell_x = CELL_W'(cx);
		w.cell_y = CELL_W'(cy);
		w.first_gid = GID_W'($urandom());
		w.entry_index = 3'($urandom());
		return w;
	endfunction

	// Mostly well-formed words: ids near a loaded first id, plus reloads and noise
	function automatic tile_word_t random_word();
		tile_word_t w;
		int r, e;
		logic [31:0] raw;
		r = $urandom_range(99);
		if (r < 15) begin
			w = load_word($urandom_range(7),
				($urandom_range(99) < 70) ? $urandom_range(1, 2000) : $urandom_range(1, 29'h1FFFFFFF),
				($urandom_range(99) < 3) ? 0 : $urandom_range(1, 4095),
				$urandom_range(255), $urandom_range(255),
				$urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(99) < 80);
			if ($urandom_range(9) == 0) w.sheet_columns = COL_W'($urandom_range(1, 8));
		end else begin
			if (r < 90) begin
				e = $urandom_range(7);
				raw[28:0] = GID_W'(sb.sheets[e].first_gid +
					(($urandom_range(9) == 0) ? $urandom_range(70000) : $urandom_range(300)));
				raw[31:29] = 3'($urandom());
			end else begin
				raw = $urandom();
			end
			w = tile_word(raw, $urandom_range(1023), $urandom_range(1023));
		end
		return w;
	endfunction

	initial begin
		int phase_pct[4][2];
		logic [2:0] fl;
		phase_pct = '{'{0, 0}, '{82, 0}, '{0, 82}, '{28, 28}};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every table entry before any lookup
		send_word(load_word(0, 1, 1, 0, 0, 1, 1, 1));
		send_word(load_word(1, 100, 4095, 255, 255, 256, 256, 1));
		send_word(load_word(2, 200, 3, 7, 2, 16, 32, 1));
		send_word(load_word(3, 300, 5, 1, 1, 8, 8, 0));
		send_word(load_word(4, 400, 10, 0, 4, 24, 12, 1));
		send_word(load_word(5, 500, 0, 3, 3, 16, 16, 1));
		send_word(load_word(6, 600, 1, 255, 255, 256, 256, 1));
		send_word(load_word(7, 29'h1FFFFF00, 64, 2, 0, 32, 32, 1));
		drain();
		write_reg(CFG_TILE_W, 9'd256);
		write_reg(CFG_TILE_H, 9'd1);
		write_reg(CFG_SET_COUNT, 9'd8);

		// Directed tiles: id zero, every flip combination, unowned and skipped sheets
		send_word(tile_word(32'hE000_0000, 5, 5));
		send_word(tile_word(32'h0000_0000, 0, 0));
		for (int f = 0; f < 8; f++) begin
			fl = 3'(f);
			send_word(tile_word({fl, 29'd217}, 1023, 1023));
		end
		send_word(tile_word(32'd100 + 32'd65535, 3, 4));
		send_word(tile_word(32'd100 + 32'd65536 + 32'd50, 3, 4));
		send_word(tile_word(32'd302, 1, 1));
		send_word(tile_word(32'd505, 1, 1));
		send_word(tile_word(32'd600 + 32'd65535, 0, 1023));
		send_word(tile_word(32'hFFFF_FFFF, 1023, 0));
		send_word(tile_word(32'h1FFFFF00, 7, 7));
		send_word(tile_word(32'd1, 0, 0));
		drain();
		write_reg(CFG_SET_COUNT, 9'd0);
		send_word(tile_word(32'd5, 2, 2));
		drain();
		write_reg(CFG_SET_COUNT, 9'd15);
		send_word(tile_word(32'h8000_0250, 2, 2));

		for (int p = 0; p < 4; p++) begin
			drain();
			write_reg(CFG_TILE_W, (p == 0) ? 9'd1 : 9'($urandom_range(1, 256)));
			write_reg(CFG_TILE_H, (p == 1) ? 9'd256 : 9'($urandom_range(1, 256)));
			write_reg(CFG_SET_COUNT, (p == 3) ? 9'd8 : 9'($urandom_range(0, 15)));
			send_idle_pct = phase_pct[p][0];
			recv_stall_pct = phase_pct[p][1];
			for (int n = 0; n < 345; n++) begin
				if (p == 0 && n == 100) hold_go = 1;
				// Pause until every pending blit is out
				if (p == 0 && n == 250) begin
					in_valid <= 1'b0;
					while (sb.pending_blits.size() != 0) @(posedge clk);
				end
				send_word(random_word());
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();

		$display("covered %0d table loads, %0d tiles checked (%0d drawn), %0d register writes",
			sb.loads, sb.checked, sb.drawn_seen, cfg_writes);
		$display("four idle and stall mixes, one long output hold and one full drain pause");
		if (sb.mismatches == 0 && sb.pending_blits.size() == 0) begin
			$display("[tile_gid_to_blit_decoder_core] OK");
		end else begin
			$display("[tile_gid_to_blit_decoder_core] ERROR");
		end
		$finish;
	end

endmodule
